FILE: hdl/srsw_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// srsw_pkg: shared types and constants of the selective-repeat send window
// Holds the word formats of the command and result channels, the
// configuration layout, the operation and result codes and the defaults.
// ============================================================================
package srsw_pkg;

  // Default sizing of the window and of the age counters.
  localparam int unsigned MAX_WINDOW_DEF = 8;
  localparam int unsigned AGE_BITS_DEF   = 16;

  // At most this many retransmits are reported for one tick.
  localparam int unsigned MAX_RESULTS = 8;

  // Sequence numbers wrap modulo this value, so they run up to SEQ_MOD - 1.
  localparam logic [15:0] SEQ_MOD = 16'hFFFF;

  // Configuration port layout and register reset values.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd2;

  localparam logic [3:0]  WINDOW_RST  = 4'd8;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [15:0] TOTAL_RST   = 16'd0;

  // Operation codes of an input word. The last code is not assigned and
  // acts as a no-op.
  localparam logic [1:0] OP_OFFER  = 2'd0;
  localparam logic [1:0] OP_ACK    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result codes.
  typedef enum logic [2:0] {
    KIND_IDLE        = 3'd0,
    KIND_SEND        = 3'd1,
    KIND_RETX        = 3'd2,
    KIND_REFUSED     = 3'd3,
    KIND_ACK_TAKEN   = 3'd4,
    KIND_ACK_DROPPED = 3'd5
  } kind_t;

  // Classified command handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_OFFER,
    CMD_ACK,
    CMD_TICK,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] ack_seq;
    logic        ack_ok;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] seq_out;
    logic [15:0] base_now;
    logic        done_res;
    logic        last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t   cmd;
    logic [15:0] ack_seq;
    logic        ack_good;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  window;
    logic [15:0] timeout;
    logic [15:0] total;
  } cfg_t;

endpackage

FILE: hdl/selective_repeat_send_window.sv
`timescale 1ns / 1ps
// An offer, a dropped ack or an unknown op is queued and, once the back end is idle, executed
// with a registered result; a taken ack first slides the base past the acknowledged prefix.
// A tick reads one slot age a cycle and gives its retransmits at most one a cycle, the last
// result at the end of the pass. The back end takes a word from the queue only when idle;
// busy means the two-word queue is full. Synchronous reset clears the window; registers
// take 8, 500 and 0.
// ============================================================================
// selective_repeat_send_window: sender side of a selective-repeat ARQ window
// Configuration registers, the command front end and the window back end.
// ============================================================================
module selective_repeat_send_window #(
  parameter int unsigned MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF,
  parameter int unsigned AGE_BITS   = srsw_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  srsw_pkg::in_item_t                  in_data,
  output logic                                out_strobe,
  output srsw_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  srsw_pkg::cfg_t cfg_r;
  logic           cmd_vld;
  srsw_pkg::cmd_t cmd;
  logic           pop;

  // Configuration registers; writes to an unused index are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window  <= srsw_pkg::WINDOW_RST;
      cfg_r.timeout <= srsw_pkg::TIMEOUT_RST;
      cfg_r.total   <= srsw_pkg::TOTAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        srsw_pkg::CFG_WINDOW:  cfg_r.window  <= cfg_wdata[3:0];
        srsw_pkg::CFG_TIMEOUT: cfg_r.timeout <= cfg_wdata[15:0];
        srsw_pkg::CFG_TOTAL:   cfg_r.total   <= cfg_wdata[15:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  srsw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .pop     (pop),
    .cmd_vld (cmd_vld),
    .cmd     (cmd)
  );

  srsw_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .AGE_BITS   (AGE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd_vld    (cmd_vld),
    .cmd        (cmd),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

FILE: hdl/srsw_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// srsw_ram: generic single-write, single-read RAM
// One write and one registered read per cycle; contents are not reset.
// ============================================================================
module srsw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/srsw_front.sv
`timescale 1ns / 1ps
// ============================================================================
// srsw_front: command intake and classification
// Accepts input words, decodes the operation, pre-checks an ack for a valid
// checksum and a legal sequence number, and queues the command for the back
// end in a two-entry queue.
// ============================================================================
module srsw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  srsw_pkg::in_item_t in_data,
  input  logic               pop,
  output logic               cmd_vld,
  output srsw_pkg::cmd_t     cmd
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  srsw_pkg::cmd_t    q_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  srsw_pkg::cmd_t    cls;

  assign busy    = (cnt_r == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign cmd_vld = (cnt_r != '0);
  assign cmd     = q_r[rd_ptr_r];

  // Decode the operation and pre-check the ack word.
  always_comb begin
    cls.ack_seq  = in_data.ack_seq;
    cls.ack_good = in_data.ack_ok && (in_data.ack_seq != srsw_pkg::SEQ_MOD);
    unique case (in_data.op)
      srsw_pkg::OP_OFFER: cls.cmd = srsw_pkg::CMD_OFFER;
      srsw_pkg::OP_ACK:   cls.cmd = srsw_pkg::CMD_ACK;
      srsw_pkg::OP_TICK:  cls.cmd = srsw_pkg::CMD_TICK;
      default:            cls.cmd = srsw_pkg::CMD_NOP;
    endcase
  end

  // Queue pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: hdl/srsw_back.sv
`timescale 1ns / 1ps
// ============================================================================
// srsw_back: window state and command execution
// Keeps the window as a ring of slots with a head pointer, executes offers,
// acks with the base slide, and ticks that age and retransmit the slots.
// Slot ages live in a small RAM; a tick streams through it one slot a cycle.
// ============================================================================
module srsw_back #(
  parameter int unsigned MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF,
  parameter int unsigned AGE_BITS   = srsw_pkg::AGE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srsw_pkg::cfg_t      cfg,
  input  logic                cmd_vld,
  input  srsw_pkg::cmd_t      cmd,
  output logic                pop,
  output logic                out_strobe,
  output srsw_pkg::out_item_t out_data
);

  localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = IDX_W + 1;
  localparam int unsigned EW    = (CNT_W > 4) ? CNT_W : 4;
  localparam int unsigned CW    = (AGE_BITS > 16) ? AGE_BITS : 16;
  localparam int unsigned RES_W = $clog2(srsw_pkg::MAX_RESULTS + 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLIDE,
    ST_TICK
  } state_t;

  state_t              state_r, state_nxt;
  logic [15:0]         base_r, base_nxt;
  logic [15:0]         next_r, next_nxt;
  logic [15:0]         issued_r, issued_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    outs_r, outs_nxt;
  logic [MAX_WINDOW-1:0] acked_r, acked_nxt;
  logic [CNT_W-1:0]    rd_i_r, rd_i_nxt;
  logic                p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]    p_i_r, p_i_nxt;
  logic [RES_W-1:0]    n_r, n_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [15:0]         pend_seq_r, pend_seq_nxt;
  logic                out_vld_r, out_vld_nxt;
  srsw_pkg::out_item_t out_r, out_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [AGE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [AGE_BITS-1:0] ram_rdata;

  logic [EW-1:0]       win_eff;
  logic                offer_ok;
  logic [IDX_W-1:0]    slot_new;
  logic [15:0]         ack_dist;
  logic                ack_hit;
  logic [IDX_W-1:0]    slot_ack;
  logic [IDX_W-1:0]    p_phys;
  logic [15:0]         p_seq;
  logic [AGE_BITS-1:0] age_inc;
  logic                due;
  logic                retx;

  // Physical slot of the logical offset ofs from the head.
  function automatic logic [IDX_W-1:0] slot_phys(input logic [IDX_W-1:0] head,
                                                 input logic [SUM_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + ofs;
    if (sum >= SUM_W'(MAX_WINDOW)) begin
      sum = sum - SUM_W'(MAX_WINDOW);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Sequence number plus a small offset, modulo the sequence space.
  function automatic logic [15:0] seq_plus(input logic [15:0] s, input logic [15:0] ofs);
    logic [16:0] sum;
    sum = {1'b0, s} + {1'b0, ofs};
    if (sum >= {1'b0, srsw_pkg::SEQ_MOD}) begin
      sum = sum - {1'b0, srsw_pkg::SEQ_MOD};
    end
    return sum[15:0];
  endfunction

  function automatic srsw_pkg::out_item_t mk_res(input srsw_pkg::kind_t kind,
                                                 input logic [15:0] seq,
                                                 input logic [15:0] base,
                                                 input logic [15:0] total,
                                                 input logic last);
    srsw_pkg::out_item_t r;
    r.kind     = kind;
    r.seq_out  = seq;
    r.base_now = base;
    r.done_res = (base == total);
    r.last     = last;
    return r;
  endfunction

  srsw_ram #(
    .WIDTH (AGE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_age_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Offer check: effective window size and remaining packets.
  always_comb begin
    if (cfg.window == '0) begin
      win_eff = EW'(1);
    end else if (EW'(cfg.window) > EW'(MAX_WINDOW)) begin
      win_eff = EW'(MAX_WINDOW);
    end else begin
      win_eff = EW'(cfg.window);
    end
    offer_ok = (EW'(outs_r) < win_eff) && (issued_r < cfg.total);
    slot_new = slot_phys(head_r, SUM_W'(outs_r));
  end

  // Ack check: distance from the base must fall inside the outstanding range.
  always_comb begin
    if (cmd.ack_seq >= base_r) begin
      ack_dist = cmd.ack_seq - base_r;
    end else begin
      ack_dist = cmd.ack_seq + (srsw_pkg::SEQ_MOD - base_r);
    end
    ack_hit  = cmd.ack_good && (ack_dist < 16'(outs_r));
    slot_ack = slot_phys(head_r, ack_dist[SUM_W-1:0]);
  end

  // Aging of the slot whose age was read in the previous cycle.
  always_comb begin
    p_phys  = slot_phys(head_r, SUM_W'(p_i_r));
    p_seq   = seq_plus(base_r, 16'(p_i_r));
    age_inc = (ram_rdata == AGE_MAX) ? ram_rdata : ram_rdata + AGE_BITS'(1);
    due     = (CW'(age_inc) >= CW'(cfg.timeout)) || (age_inc == AGE_MAX);
    retx    = due && (n_r < RES_W'(srsw_pkg::MAX_RESULTS));
  end

  // Command sequencer.
  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    next_nxt     = next_r;
    issued_nxt   = issued_r;
    head_nxt     = head_r;
    outs_nxt     = outs_r;
    acked_nxt    = acked_r;
    rd_i_nxt     = rd_i_r;
    p_vld_nxt    = p_vld_r;
    p_i_nxt      = p_i_r;
    n_nxt        = n_r;
    pend_vld_nxt = pend_vld_r;
    pend_seq_nxt = pend_seq_r;
    out_vld_nxt  = 1'b0;
    out_nxt      = out_r;
    pop          = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = slot_new;
    ram_wdata    = '0;
    ram_raddr    = slot_phys(head_r, SUM_W'(rd_i_r));

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          pop = 1'b1;
          unique case (cmd.cmd)
            srsw_pkg::CMD_OFFER: begin
              out_vld_nxt = 1'b1;
              if (offer_ok) begin
                acked_nxt[slot_new] = 1'b0;
                ram_we     = 1'b1;
                ram_waddr  = slot_new;
                next_nxt   = seq_plus(next_r, 16'd1);
                issued_nxt = issued_r + 16'd1;
                outs_nxt   = outs_r + CNT_W'(1);
                out_nxt    = mk_res(srsw_pkg::KIND_SEND, next_r, base_r, cfg.total, 1'b1);
              end else begin
                out_nxt = mk_res(srsw_pkg::KIND_REFUSED, 16'd0, base_r, cfg.total, 1'b1);
              end
            end
            srsw_pkg::CMD_ACK: begin
              if (ack_hit) begin
                acked_nxt[slot_ack] = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = slot_ack;
                state_nxt = ST_SLIDE;
              end else begin
                out_vld_nxt = 1'b1;
                out_nxt = mk_res(srsw_pkg::KIND_ACK_DROPPED, 16'd0, base_r, cfg.total,
                                 1'b1);
              end
            end
            srsw_pkg::CMD_TICK: begin
              rd_i_nxt     = '0;
              p_vld_nxt    = 1'b0;
              n_nxt        = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = ST_TICK;
            end
            srsw_pkg::CMD_NOP: begin
              out_vld_nxt = 1'b1;
              out_nxt = mk_res(srsw_pkg::KIND_IDLE, 16'd0, base_r, cfg.total, 1'b1);
            end
          endcase
        end
      end

      // Slide the base past the acknowledged prefix, one slot a cycle.
      ST_SLIDE: begin
        if ((outs_r != '0) && acked_r[head_r]) begin
          acked_nxt[head_r] = 1'b0;
          head_nxt = slot_phys(head_r, SUM_W'(1));
          base_nxt = seq_plus(base_r, 16'd1);
          outs_nxt = outs_r - CNT_W'(1);
        end else begin
          out_vld_nxt = 1'b1;
          out_nxt = mk_res(srsw_pkg::KIND_ACK_TAKEN, 16'd0, base_r, cfg.total, 1'b1);
          state_nxt = ST_IDLE;
        end
      end

      // Read one age a cycle, age and write back the one read before. A
      // retransmit is held back one step so that the final one carries last.
      ST_TICK: begin
        if (rd_i_r != outs_r) begin
          rd_i_nxt  = rd_i_r + CNT_W'(1);
          p_vld_nxt = 1'b1;
          p_i_nxt   = rd_i_r[IDX_W-1:0];
        end else begin
          p_vld_nxt = 1'b0;
        end

        if (p_vld_r && !acked_r[p_phys]) begin
          ram_we    = 1'b1;
          ram_waddr = p_phys;
          if (retx) begin
            ram_wdata    = '0;
            n_nxt        = n_r + RES_W'(1);
            pend_vld_nxt = 1'b1;
            pend_seq_nxt = p_seq;
            if (pend_vld_r) begin
              out_vld_nxt = 1'b1;
              out_nxt = mk_res(srsw_pkg::KIND_RETX, pend_seq_r, base_r, cfg.total, 1'b0);
            end
          end else begin
            ram_wdata = age_inc;
          end
        end

        if ((rd_i_r == outs_r) && !p_vld_r) begin
          out_vld_nxt = 1'b1;
          if (pend_vld_r) begin
            out_nxt = mk_res(srsw_pkg::KIND_RETX, pend_seq_r, base_r, cfg.total, 1'b1);
          end else begin
            out_nxt = mk_res(srsw_pkg::KIND_IDLE, 16'd0, base_r, cfg.total, 1'b1);
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      base_r     <= '0;
      next_r     <= '0;
      issued_r   <= '0;
      head_r     <= '0;
      outs_r     <= '0;
      acked_r    <= '0;
      rd_i_r     <= '0;
      p_vld_r    <= 1'b0;
      n_r        <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      base_r     <= base_nxt;
      next_r     <= next_nxt;
      issued_r   <= issued_nxt;
      head_r     <= head_nxt;
      outs_r     <= outs_nxt;
      acked_r    <= acked_nxt;
      rd_i_r     <= rd_i_nxt;
      p_vld_r    <= p_vld_nxt;
      n_r        <= n_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    p_i_r      <= p_i_nxt;
    pend_seq_r <= pend_seq_nxt;
    out_r      <= out_nxt;
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  a_outs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outs_r <= CNT_W'(MAX_WINDOW))
    else $error("outstanding count exceeds the window");

  a_outs_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (next_r - base_r - ((next_r < base_r) ? 16'd1 : 16'd0)) == 16'(outs_r))
    else $error("outstanding count disagrees with the sequence pointers");

  a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    (base_r != srsw_pkg::SEQ_MOD) && (next_r != srsw_pkg::SEQ_MOD))
    else $error("sequence pointer left the sequence space");

  a_retx_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> (n_r <= RES_W'(srsw_pkg::MAX_RESULTS)))
    else $error("too many retransmits in one tick");

  a_pop_progress: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_vld_r || (state_r != ST_IDLE)))
    else $error("command taken without result or further work");
`endif

endmodule
